FILE: hw/rtl/resp_rp_pkg.sv
`default_nettype none
package resp_rp_pkg;

  localparam int DEF_MAX_ARGS    = 255;
  localparam int DEF_MAX_ARG_LEN = 65535;
  localparam int QDEPTH          = 4;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [16:0] SAT17 = 17'h1FFFF;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_ARG  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_COUNT    = 2'd1;
  localparam logic [1:0] ERR_LENGTH   = 2'd2;
  localparam logic [1:0] ERR_MISMATCH = 2'd3;

  // one classified item: a held CR, a byte, a held CR then a byte, or a line end
  typedef struct packed {
    logic       feed_cr;
    logic       feed_ch;
    logic       end_line;
    logic [7:0] ch;
  } op_t;

endpackage
`default_nettype wire

FILE: hw/rtl/resp_rp_front.sv
`default_nettype none
module resp_rp_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_byte,
  input  wire logic             q_full,
  output logic                  push,
  output resp_rp_pkg::op_t      push_op
);

  logic cr_pending_r;
  logic cr_pending_nxt;
  logic accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    push_op        = '0;
    push_op.ch     = in_byte;
    push           = 1'b0;
    cr_pending_nxt = cr_pending_r;
    if (accept) begin
      if (cr_pending_r) begin
        if (in_byte == resp_rp_pkg::CH_LF) begin
          push_op.end_line = 1'b1;
          cr_pending_nxt   = 1'b0;
        end else begin
          push_op.feed_cr = 1'b1;
          push_op.feed_ch = (in_byte != resp_rp_pkg::CH_CR);
          cr_pending_nxt  = (in_byte == resp_rp_pkg::CH_CR);
        end
        push = 1'b1;
      end else if (in_byte == resp_rp_pkg::CH_CR) begin
        cr_pending_nxt = 1'b1;
      end else begin
        push_op.feed_ch = 1'b1;
        push            = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cr_pending_r <= 1'b0;
    end else begin
      cr_pending_r <= cr_pending_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/resp_rp_fifo.sv
`default_nettype none
module resp_rp_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire resp_rp_pkg::op_t  push_op,
  output logic                   full,
  output logic                   not_empty,
  output resp_rp_pkg::op_t       head_op,
  input  wire logic              pop
);

  localparam int PW = $clog2(resp_rp_pkg::QDEPTH);
  localparam int CW = $clog2(resp_rp_pkg::QDEPTH + 1);

  resp_rp_pkg::op_t mem_r [resp_rp_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full      = (count_r == CW'(resp_rp_pkg::QDEPTH));
  assign not_empty = (count_r != '0);
  assign head_op   = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(resp_rp_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(resp_rp_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/resp_rp_back.sv
`default_nettype none
module resp_rp_back #(
  parameter int MAX_ARGS    = resp_rp_pkg::DEF_MAX_ARGS,
  parameter int MAX_ARG_LEN = resp_rp_pkg::DEF_MAX_ARG_LEN
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              op_valid,
  input  wire resp_rp_pkg::op_t  op,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             out_kind,
  output logic [7:0]             out_data_byte,
  output logic [7:0]             out_arg_index,
  output logic                   out_request_done,
  output logic [1:0]             out_error_code,
  output logic                   out_last
);

  typedef enum logic [2:0] {
    PH_HDR  = 3'b001,
    PH_LEN  = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic        line_start;
    logic        marker_bad;
    logic [16:0] accum;
    logic        negative;
    logic        num_done;
    logic        started;
    logic [7:0]  args_total;
    logic [7:0]  cur_arg;
    logic [15:0] decl_len;
    logic [16:0] data_count;
  } st_t;

  function automatic st_t feed_fn(st_t s, logic [7:0] c);
    st_t         r;
    logic [20:0] v;
    logic [7:0]  want;
    r    = s;
    v    = ({4'b0, s.accum} << 3) + ({4'b0, s.accum} << 1) + {17'b0, c[3:0]};
    want = (s.phase == PH_LEN) ? resp_rp_pkg::CH_DOLLAR : resp_rp_pkg::CH_STAR;
    if (s.phase == PH_DATA) begin
      if (s.data_count != resp_rp_pkg::SAT17) begin
        r.data_count = s.data_count + 17'd1;
      end
    end else if (s.line_start) begin
      r.line_start = 1'b0;
      if (c != want) begin
        r.marker_bad = 1'b1;
      end
    end else if (!s.marker_bad && !s.num_done) begin
      if (c >= resp_rp_pkg::CH_ZERO && c <= resp_rp_pkg::CH_NINE) begin
        r.accum   = (v > {4'b0, resp_rp_pkg::SAT17}) ? resp_rp_pkg::SAT17 : v[16:0];
        r.started = 1'b1;
      end else if (!s.started && (c == resp_rp_pkg::CH_PLUS || c == resp_rp_pkg::CH_MINUS)) begin
        r.negative = (c == resp_rp_pkg::CH_MINUS);
        r.started  = 1'b1;
      end else begin
        r.num_done = 1'b1;
      end
    end
    return r;
  endfunction

  st_t         st_r, st_nxt;
  logic        half_r, half_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic        done_r, done_nxt;
  logic [1:0]  err_r, err_nxt;
  logic        last_r, last_nxt;
  logic        step, emit;
  logic        bad, neg_len, args_done;

  assign step      = op_valid && (!out_valid_r || !out_stall);
  assign bad       = st_r.marker_bad || st_r.line_start;
  assign neg_len   = st_r.negative && (st_r.accum != '0);
  assign args_done = ({1'b0, st_r.cur_arg} + 9'd1) >= {1'b0, st_r.args_total};

  always_comb begin
    st_nxt   = st_r;
    half_nxt = half_r;
    pop      = 1'b0;
    emit     = 1'b0;
    kind_nxt = resp_rp_pkg::KIND_DATA;
    data_nxt = op.ch;
    idx_nxt  = st_r.cur_arg;
    done_nxt = 1'b0;
    err_nxt  = resp_rp_pkg::ERR_NONE;
    last_nxt = 1'b1;
    if (step) begin
      if (op.feed_cr && !half_r) begin
        st_nxt   = feed_fn(st_r, resp_rp_pkg::CH_CR);
        emit     = (st_r.phase == PH_DATA);
        data_nxt = resp_rp_pkg::CH_CR;
        last_nxt = !op.feed_ch;
        half_nxt = op.feed_ch;
        pop      = !op.feed_ch;
      end else if (op.end_line) begin
        pop      = 1'b1;
        half_nxt = 1'b0;
        data_nxt = '0;
        emit     = 1'b0;
        case (st_r.phase)
          PH_DATA: begin
            emit = 1'b1;
            if (st_r.data_count != {1'b0, st_r.decl_len}) begin
              kind_nxt       = resp_rp_pkg::KIND_ERR;
              err_nxt        = resp_rp_pkg::ERR_MISMATCH;
              st_nxt.phase   = PH_HDR;
              st_nxt.cur_arg = '0;
            end else begin
              kind_nxt = resp_rp_pkg::KIND_ARG;
              done_nxt = args_done;
              if (args_done) begin
                st_nxt.phase   = PH_HDR;
                st_nxt.cur_arg = '0;
              end else begin
                st_nxt.phase   = PH_LEN;
                st_nxt.cur_arg = st_r.cur_arg + 8'd1;
              end
            end
          end
          PH_LEN: begin
            if (bad || neg_len || st_r.accum > 17'(MAX_ARG_LEN)) begin
              emit           = 1'b1;
              kind_nxt       = resp_rp_pkg::KIND_ERR;
              err_nxt        = resp_rp_pkg::ERR_LENGTH;
              st_nxt.phase   = PH_HDR;
              st_nxt.cur_arg = '0;
            end else begin
              st_nxt.decl_len   = st_r.accum[15:0];
              st_nxt.data_count = '0;
              st_nxt.phase      = PH_DATA;
            end
          end
          default: begin
            if (bad || st_r.negative || st_r.accum == '0 ||
                st_r.accum > 17'(MAX_ARGS)) begin
              emit           = 1'b1;
              kind_nxt       = resp_rp_pkg::KIND_ERR;
              err_nxt        = resp_rp_pkg::ERR_COUNT;
              idx_nxt        = '0;
              st_nxt.phase   = PH_HDR;
              st_nxt.cur_arg = '0;
            end else begin
              st_nxt.args_total = st_r.accum[7:0];
              st_nxt.cur_arg    = '0;
              st_nxt.phase      = PH_LEN;
            end
          end
        endcase
        st_nxt.line_start = 1'b1;
        st_nxt.marker_bad = 1'b0;
        st_nxt.accum      = '0;
        st_nxt.negative   = 1'b0;
        st_nxt.num_done   = 1'b0;
        st_nxt.started    = 1'b0;
      end else begin
        st_nxt   = feed_fn(st_r, op.ch);
        emit     = (st_r.phase == PH_DATA);
        pop      = 1'b1;
        half_nxt = 1'b0;
      end
    end
    out_valid_nxt = step ? emit : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase      <= PH_HDR;
      st_r.line_start <= 1'b1;
      st_r.marker_bad <= 1'b0;
      st_r.accum      <= '0;
      st_r.negative   <= 1'b0;
      st_r.num_done   <= 1'b0;
      st_r.started    <= 1'b0;
      st_r.args_total <= '0;
      st_r.cur_arg    <= '0;
      st_r.decl_len   <= '0;
      st_r.data_count <= '0;
      half_r          <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      half_r      <= half_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      kind_r <= kind_nxt;
      data_r <= data_nxt;
      idx_r  <= idx_nxt;
      done_r <= done_nxt;
      err_r  <= err_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_data_byte    = data_r;
  assign out_arg_index    = idx_r;
  assign out_request_done = done_r;
  assign out_error_code   = err_r;
  assign out_last         = last_r;

endmodule
`default_nettype wire

FILE: hw/rtl/resp_request_parser_top.sv
// Path: an accepted byte is written to the item queue; the line engine then reads it
// and registers its result; a byte that flushes a held CR gives the CR result first.
// Throughput: one byte per cycle while in_stall is low; a byte that follows a held CR
// and is not LF makes the line engine play out the CR first, as a step of its own.
// A 4-entry item queue between the byte classifier and the line engine absorbs that.
// Reset (synchronous, rst_n low): empty queue, parser waits for a '*' header line.
`default_nettype none
module resp_request_parser_top #(
  parameter int MAX_ARGS    = resp_rp_pkg::DEF_MAX_ARGS,
  parameter int MAX_ARG_LEN = resp_rp_pkg::DEF_MAX_ARG_LEN
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_data_byte,
  output logic [7:0]       out_arg_index,
  output logic             out_request_done,
  output logic [1:0]       out_error_code,
  output logic             out_last
);

  resp_rp_pkg::op_t push_op, head_op;
  logic             push, q_full, q_not_empty, pop;

  resp_rp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .push     (push),
    .push_op  (push_op)
  );

  resp_rp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_op   (push_op),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_op   (head_op),
    .pop       (pop)
  );

  resp_rp_back #(
    .MAX_ARGS    (MAX_ARGS),
    .MAX_ARG_LEN (MAX_ARG_LEN)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .op_valid         (q_not_empty),
    .op               (head_op),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_arg_index    (out_arg_index),
    .out_request_done (out_request_done),
    .out_error_code   (out_error_code),
    .out_last         (out_last)
  );

endmodule
`default_nettype wire
